@@ src/mcbd_pkg.sv @@
package mcbd_pkg;

    // Number of buttons scanned per update (1 to 16).
    localparam int NUM_BUTTONS = 16;
    localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // Fixed field widths.
    localparam int MS_W    = 16;
    localparam int LVL_W   = 16;
    localparam int BOARD_W = 8;
    localparam int BIDX_W  = 4;
    localparam int CNT_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int IN_W    = MS_W + LVL_W + BOARD_W;
    localparam int OUT_W   = BOARD_W + BIDX_W + CNT_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_DEB     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DEB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MULTI_GAP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CLICKS    = 3'd5;

    // Event kinds.
    localparam logic KIND_CLICK = 1'b0;
    localparam logic KIND_HOLD  = 1'b1;

    // Per-button mode.
    typedef enum logic [2:0] {
        MODE_AWAIT_PRESS   = 3'd0,
        MODE_DEB_PRESS     = 3'd1,
        MODE_AWAIT_RELEASE = 3'd2,
        MODE_DEB_RELEASE   = 3'd3,
        MODE_AWAIT_MULTI   = 3'd4
    } t_mode;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_FLUSH = 2'd2
    } t_state;

    typedef struct packed {
        logic              active_level;
        logic [MS_W-1:0]   press_deb;
        logic [MS_W-1:0]   release_deb;
        logic [MS_W-1:0]   hold;
        logic [MS_W-1:0]   multi_gap;
        logic [CNT_W-1:0]  max_clicks;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic flush;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;
        logic pend_valid;
        logic slot_free;
        logic last_idx;
    } t_stat;

endpackage

@@ src/multi_click_button_detector_unit.sv @@
// Multi-click and hold detector for up to sixteen buttons. Each input beat
// carries the milliseconds elapsed since the previous beat, the raw button
// levels and a board id; the block scans the buttons one per clock cycle
// unless a new event waits on a held output beat, updating each button's
// debounce, hold and click-gap state, and sends one output beat per event
// in ascending button order, with tlast on the final event of that input.
// An input is accepted in the idle state, scanned in the shared update unit
// and its last event sent in the flush state. An input that causes no event
// gives no output beat. The next input is accepted while the final event of
// the previous one still waits in the output register.
module multi_click_button_detector_unit
    import mcbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // Input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,  // elapsed_ms, button_levels, board_id
    // Event stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,  // event_board, button_index, click_count
    output logic                 m_axis_tuser,  // event_kind
    output logic                 m_axis_tlast
);

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    mcbd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    mcbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mcbd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

@@ src/mcbd_cfg.sv @@
module mcbd_cfg
    import mcbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Register file, written one register at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level <= 1'b0;
            r_cfg.press_deb    <= 16'd15;
            r_cfg.release_deb  <= 16'd30;
            r_cfg.hold         <= 16'd1000;
            r_cfg.multi_gap    <= 16'd400;
            r_cfg.max_clicks   <= 4'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ACTIVE_LEVEL: r_cfg.active_level <= i_cfg_data[0];
                REG_PRESS_DEB:    r_cfg.press_deb    <= i_cfg_data;
                REG_RELEASE_DEB:  r_cfg.release_deb  <= i_cfg_data;
                REG_HOLD:         r_cfg.hold         <= i_cfg_data;
                REG_MULTI_GAP:    r_cfg.multi_gap    <= i_cfg_data;
                REG_MAX_CLICKS:   r_cfg.max_clicks   <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/mcbd_ctrl.sv @@
module mcbd_ctrl
    import mcbd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   w_stall;

    // A new event cannot displace the pending one while the output beat is held.
    assign w_stall = i_stat.emit && i_stat.pend_valid && !i_stat.slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (!w_stall && i_stat.last_idx) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!i_stat.pend_valid || i_stat.slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.step = !w_stall;
            end
            ST_FLUSH: begin
                o_cmd.flush = i_stat.pend_valid && i_stat.slot_free;
            end
            default: ;
        endcase
    end

endmodule

@@ src/mcbd_datapath.sv @@
module mcbd_datapath
    import mcbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic [IN_W-1:0]    i_in_data,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [OUT_W-1:0]   o_out_data,
    output logic               o_out_kind,
    output logic               o_out_last
);

    // Item registers.
    logic [MS_W-1:0]    r_elapsed;
    logic [LVL_W-1:0]   r_levels;
    logic [BOARD_W-1:0] r_board;
    logic [IDX_W-1:0]   r_idx;

    // Per-button state.
    t_mode              r_mode  [NUM_BUTTONS];
    logic [CNT_W-1:0]   r_tally [NUM_BUTTONS];
    logic               r_hold  [NUM_BUTTONS];
    logic [MS_W-1:0]    r_timer [NUM_BUTTONS];

    // Pending event, held until we know whether another follows.
    logic               r_pend_valid;
    logic [BIDX_W-1:0]  r_pend_idx;
    logic               r_pend_kind;
    logic [CNT_W-1:0]   r_pend_count;

    // Output register.
    logic               r_out_valid;
    logic [BOARD_W-1:0] r_out_board;
    logic [BIDX_W-1:0]  r_out_idx;
    logic               r_out_kind;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_last;

    // Next values for the button being scanned.
    t_mode              n_mode;
    logic [CNT_W-1:0]   n_tally;
    logic               n_hold;
    logic [MS_W-1:0]    n_timer;
    logic               w_emit;
    logic               w_kind;
    logic [CNT_W-1:0]   w_count;
    logic               w_pressed;
    logic [MS_W:0]      w_sum;
    logic [MS_W-1:0]    w_timer;
    logic [CNT_W-1:0]   w_cap;
    logic [CNT_W:0]     w_inc;
    logic               w_slot_free;

    assign w_pressed = (r_levels[BIDX_W'(r_idx)] == i_cfg.active_level);
    assign w_sum     = {1'b0, r_timer[r_idx]} + {1'b0, r_elapsed};
    assign w_timer   = w_sum[MS_W] ? {MS_W{1'b1}} : w_sum[MS_W-1:0];
    assign w_cap     = (i_cfg.max_clicks == '0) ? CNT_W'(1) : i_cfg.max_clicks;
    assign w_inc     = {1'b0, r_tally[r_idx]} + (CNT_W+1)'(1);

    // One button's mode update.
    always_comb begin
        n_mode  = r_mode[r_idx];
        n_tally = r_tally[r_idx];
        n_hold  = r_hold[r_idx];
        n_timer = w_timer;
        w_emit  = 1'b0;
        w_kind  = KIND_CLICK;
        w_count = '0;
        unique case (r_mode[r_idx])
            MODE_DEB_PRESS: begin
                if (w_timer > i_cfg.press_deb) begin
                    n_mode  = MODE_AWAIT_RELEASE;
                    n_timer = '0;
                end
            end
            MODE_AWAIT_RELEASE: begin
                if (!w_pressed) begin
                    n_mode  = MODE_DEB_RELEASE;
                    n_timer = '0;
                end else if (w_timer > i_cfg.hold) begin
                    n_hold  = 1'b1;
                    n_timer = '0;
                    w_emit  = 1'b1;
                    w_kind  = KIND_HOLD;
                end
            end
            MODE_DEB_RELEASE: begin
                if (w_timer > i_cfg.release_deb) begin
                    if (r_hold[r_idx]) begin
                        n_mode = MODE_AWAIT_PRESS;
                    end else begin
                        n_tally = (w_inc > {1'b0, w_cap}) ? w_cap : w_inc[CNT_W-1:0];
                        n_mode  = MODE_AWAIT_MULTI;
                        n_timer = '0;
                    end
                end
            end
            MODE_AWAIT_MULTI: begin
                if (w_pressed) begin
                    n_mode  = MODE_DEB_PRESS;
                    n_timer = '0;
                end else if (w_timer > i_cfg.multi_gap) begin
                    n_mode  = MODE_AWAIT_PRESS;
                    w_emit  = 1'b1;
                    w_count = r_tally[r_idx];
                end
            end
            default: begin
                n_tally = '0;
                n_hold  = 1'b0;
                n_mode  = MODE_AWAIT_PRESS;
                if (w_pressed) begin
                    n_mode  = MODE_DEB_PRESS;
                    n_timer = '0;
                end
            end
        endcase
    end

    // Item capture and scan index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_elapsed <= i_in_data[MS_W-1:0];
            r_levels  <= i_in_data[MS_W+LVL_W-1:MS_W];
            r_board   <= i_in_data[IN_W-1:MS_W+LVL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.step && !o_stat.last_idx) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Button state write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_mode[b]  <= MODE_AWAIT_PRESS;
                r_tally[b] <= '0;
                r_hold[b]  <= 1'b0;
                r_timer[b] <= '0;
            end
        end else if (i_cmd.step) begin
            r_mode[r_idx]  <= n_mode;
            r_tally[r_idx] <= n_tally;
            r_hold[r_idx]  <= n_hold;
            r_timer[r_idx] <= n_timer;
        end
    end

    assign w_slot_free = !r_out_valid || i_out_ready;

    // Pending event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.step && w_emit) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_emit) begin
            r_pend_idx   <= BIDX_W'(r_idx);
            r_pend_kind  <= w_kind;
            r_pend_count <= w_count;
        end
    end

    // Output beat: a displaced pending event is not last, a flushed one is.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.step && w_emit && r_pend_valid) || i_cmd.flush) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.step && w_emit && r_pend_valid) || i_cmd.flush) begin
            r_out_board <= r_board;
            r_out_idx   <= r_pend_idx;
            r_out_kind  <= r_pend_kind;
            r_out_count <= r_pend_count;
            r_out_last  <= i_cmd.flush;
        end
    end

    assign o_stat.emit       = w_emit;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.slot_free  = w_slot_free;
    assign o_stat.last_idx   = (r_idx == IDX_W'(NUM_BUTTONS - 1));

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out_count, r_out_idx, r_out_board};
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;

endmodule

@@ tb/tb_top.sv @@
module tb_top
    import mcbd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 2 * (NUM_BUTTONS + 2) + 4;
    localparam int WATCHDOG_LIMIT = 2000;

    // One button event as it leaves the block.
    typedef struct packed {
        logic [BOARD_W-1:0] board;
        logic [BIDX_W-1:0]  button;
        logic               kind;
        logic [CNT_W-1:0]   count;
        logic               last;
    } t_button_event;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    // Shadow copy of the settings.
    logic             cfg_active_level;
    logic [MS_W-1:0]  cfg_press_deb;
    logic [MS_W-1:0]  cfg_release_deb;
    logic [MS_W-1:0]  cfg_hold;
    logic [MS_W-1:0]  cfg_multi_gap;
    logic [CNT_W-1:0] cfg_max_clicks;

    // Shadow copy of the per-button state.
    t_mode            btn_mode  [NUM_BUTTONS];
    logic [CNT_W-1:0] btn_tally [NUM_BUTTONS];
    logic             btn_held  [NUM_BUTTONS];
    logic [MS_W-1:0]  btn_timer [NUM_BUTTONS];

    t_button_event pending_events[$];
    t_button_event seen_event;
    t_button_event due_event;
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;
    int            stall_left     = 0;
    logic          idle_en        = 1'b1;
    logic [15:0]   press_intent   = '0;

    multi_click_button_detector_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s, got %0d, wanted %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Settings and button state as they stand after reset.
    function automatic void reset_shadow();
        cfg_active_level = 1'b0;
        cfg_press_deb    = 16'd15;
        cfg_release_deb  = 16'd30;
        cfg_hold         = 16'd1000;
        cfg_multi_gap    = 16'd400;
        cfg_max_clicks   = 4'd5;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            btn_mode[b]  = MODE_AWAIT_PRESS;
            btn_tally[b] = '0;
            btn_held[b]  = 1'b0;
            btn_timer[b] = '0;
        end
    endfunction

    // Scans every button for one update and queues the events it gives.
    function automatic void predict_button_scan(input logic [MS_W-1:0] elapsed,
                                                input logic [LVL_W-1:0] levels,
                                                input logic [BOARD_W-1:0] board);
        t_button_event found[$];
        t_button_event ev;
        logic [MS_W:0] sum;
        int            cap;
        int            tally_next;
        logic          pressed;
        logic          fire;
        cap = (cfg_max_clicks == 0) ? 1 : int'(cfg_max_clicks);
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            pressed = (levels[b] == cfg_active_level);
            fire    = 1'b0;
            ev      = '0;
            sum     = {1'b0, btn_timer[b]} + {1'b0, elapsed};
            btn_timer[b] = sum[MS_W] ? '1 : sum[MS_W-1:0];
            case (btn_mode[b])
                MODE_DEB_PRESS: begin
                    if (btn_timer[b] > cfg_press_deb) begin
                        btn_mode[b]  = MODE_AWAIT_RELEASE;
                        btn_timer[b] = '0;
                    end
                end
                MODE_AWAIT_RELEASE: begin
                    if (!pressed) begin
                        btn_mode[b]  = MODE_DEB_RELEASE;
                        btn_timer[b] = '0;
                    end else if (btn_timer[b] > cfg_hold) begin
                        btn_held[b]  = 1'b1;
                        btn_timer[b] = '0;
                        fire         = 1'b1;
                        ev.kind      = KIND_HOLD;
                    end
                end
                MODE_DEB_RELEASE: begin
                    if (btn_timer[b] > cfg_release_deb) begin
                        if (btn_held[b]) begin
                            btn_mode[b] = MODE_AWAIT_PRESS;
                        end else begin
                            tally_next   = int'(btn_tally[b]) + 1;
                            btn_tally[b] = CNT_W'((tally_next > cap) ? cap : tally_next);
                            btn_mode[b]  = MODE_AWAIT_MULTI;
                            btn_timer[b] = '0;
                        end
                    end
                end
                MODE_AWAIT_MULTI: begin
                    if (pressed) begin
                        btn_mode[b]  = MODE_DEB_PRESS;
                        btn_timer[b] = '0;
                    end else if (btn_timer[b] > cfg_multi_gap) begin
                        btn_mode[b] = MODE_AWAIT_PRESS;
                        fire        = 1'b1;
                        ev.kind     = KIND_CLICK;
                        ev.count    = btn_tally[b];
                    end
                end
                default: begin
                    btn_tally[b] = '0;
                    btn_held[b]  = 1'b0;
                    btn_mode[b]  = MODE_AWAIT_PRESS;
                    if (pressed) begin
                        btn_mode[b]  = MODE_DEB_PRESS;
                        btn_timer[b] = '0;
                    end
                end
            endcase
            if (fire) begin
                ev.board  = board;
                ev.button = BIDX_W'(b);
                found.push_back(ev);
            end
        end
        if (found.size() > 0)
            found[found.size()-1].last = 1'b1;
        foreach (found[k])
            pending_events.push_back(found[k]);
    endfunction

    // Checks each event beat against the oldest pending event, then predicts
    // from any update beat taken at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_event.board  = m_axis_tdata[BOARD_W-1:0];
                seen_event.button = m_axis_tdata[BOARD_W+BIDX_W-1:BOARD_W];
                seen_event.count  = m_axis_tdata[OUT_W-1:BOARD_W+BIDX_W];
                seen_event.kind   = m_axis_tuser;
                seen_event.last   = m_axis_tlast;
                if (pending_events.size() == 0) begin
                    report_mismatch("event beat with none pending",
                                    int'(seen_event.button), 0);
                end else begin
                    due_event = pending_events.pop_front();
                    if (seen_event.board !== due_event.board)
                        report_mismatch("event_board", int'(seen_event.board),
                                        int'(due_event.board));
                    if (seen_event.button !== due_event.button)
                        report_mismatch("button_index", int'(seen_event.button),
                                        int'(due_event.button));
                    if (seen_event.kind !== due_event.kind)
                        report_mismatch("event_kind", int'(seen_event.kind),
                                        int'(due_event.kind));
                    if (seen_event.count !== due_event.count)
                        report_mismatch("click_count", int'(seen_event.count),
                                        int'(due_event.count));
                    if (seen_event.last !== due_event.last)
                        report_mismatch("last_event", int'(seen_event.last),
                                        int'(due_event.last));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_button_scan(s_axis_tdata[MS_W-1:0],
                                    s_axis_tdata[MS_W+LVL_W-1:MS_W],
                                    s_axis_tdata[IN_W-1:MS_W+LVL_W]);
        end
    end

    // Event side back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (idle_en && $urandom_range(0, 5) == 0)
                stall_left <= $urandom_range(1, 9);
        end
    end

    // Ends the run when no beat moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Sends one update beat; called and returning at a falling edge, with
    // tvalid left high so that back-to-back beats follow without a gap.
    task automatic send_update(input logic [MS_W-1:0] elapsed,
                               input logic [LVL_W-1:0] levels,
                               input logic [BOARD_W-1:0] board);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {board, levels, elapsed};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Waits until every pending event has arrived and the scan has finished.
    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes all six registers, one per cycle, while the block is idle.
    task automatic apply_settings(input logic lvl, input logic [MS_W-1:0] prs,
                                  input logic [MS_W-1:0] rel, input logic [MS_W-1:0] hld,
                                  input logic [MS_W-1:0] gap, input logic [CNT_W-1:0] cap);
        logic [CFG_IDX_W-1:0] reg_idx [6];
        logic [CFG_DAT_W-1:0] reg_val [6];
        reg_idx = '{REG_ACTIVE_LEVEL, REG_PRESS_DEB, REG_RELEASE_DEB,
                    REG_HOLD, REG_MULTI_GAP, REG_MAX_CLICKS};
        reg_val = '{CFG_DAT_W'(lvl), prs, rel, hld, gap, CFG_DAT_W'(cap)};
        for (int r = 0; r < 6; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= reg_idx[r];
            i_cfg_data <= reg_val[r];
            @(negedge i_clk);
        end
        i_cfg_we         <= 1'b0;
        cfg_active_level = lvl;
        cfg_press_deb    = prs;
        cfg_release_deb  = rel;
        cfg_hold         = hld;
        cfg_multi_gap    = gap;
        cfg_max_clicks   = cap;
    endtask

    // Settings that keep waits short, so sequences finish within a few beats.
    task automatic apply_random_settings();
        apply_settings(1'($urandom_range(0, 1)), 16'($urandom_range(0, 12)),
                       16'($urandom_range(0, 12)), 16'($urandom_range(20, 150)),
                       16'($urandom_range(10, 60)), 4'($urandom_range(0, 15)));
    endtask

    // Each button mostly follows its own press intent, which changes now and
    // then; a few beats carry random levels as noise.
    task automatic run_random_updates(input int count);
        logic [MS_W-1:0]  elapsed;
        logic [LVL_W-1:0] levels;
        for (int n = 0; n < count; n++) begin
            for (int b = 0; b < NUM_BUTTONS; b++)
                if ($urandom_range(0, press_intent[b] ? 7 : 3) == 0)
                    press_intent[b] = ~press_intent[b];
            if ($urandom_range(0, 19) == 0)
                elapsed = 16'($urandom);
            else
                elapsed = 16'($urandom_range(0, 25));
            levels = cfg_active_level ? press_intent : ~press_intent;
            if ($urandom_range(0, 11) == 0)
                levels = 16'($urandom);
            send_update(elapsed, levels, 8'($urandom));
        end
    endtask

    // Two clicks on every button at once, level changes during the press
    // debounce, and sixteen events from one beat.
    task automatic test_click_all_buttons();
        send_update(16'd0,  16'h0000, 8'h00);
        send_update(16'd16, 16'hFFFF, 8'h01);
        send_update(16'd0,  16'hFFFF, 8'h02);
        send_update(16'd31, 16'h0000, 8'h03);
        send_update(16'd0,  16'h0000, 8'h04);
        send_update(16'd16, 16'hFFFF, 8'h05);
        send_update(16'd1,  16'hFFFF, 8'h06);
        send_update(16'd31, 16'hFFFF, 8'h07);
        send_update(16'd401, 16'hFFFF, 8'hFF);
        wait_until_idle();
    endtask

    // Hold on buttons 3 and 7, a timer exactly at the limit, a repeated hold
    // and the silent release after it.
    task automatic test_hold_and_silent_release();
        send_update(16'd0,    16'hFF77, 8'h10);
        send_update(16'd16,   16'hFF77, 8'h11);
        send_update(16'd1001, 16'hFF77, 8'hFF);
        send_update(16'd1000, 16'hFF77, 8'h12);
        send_update(16'd1,    16'hFF77, 8'h13);
        send_update(16'd0,    16'hFFFF, 8'h14);
        send_update(16'd31,   16'hFFFF, 8'h15);
        wait_until_idle();
    endtask

    // Largest waits with a saturating timer, then zero waits with active high
    // levels and a click cap of zero.
    task automatic test_config_extremes();
        apply_settings(1'b0, 16'd65534, 16'd65535, 16'd65534, 16'd65535, 4'd15);
        send_update(16'd0,     16'hFFFE, 8'h20);
        send_update(16'd65535, 16'hFFFE, 8'h21);
        send_update(16'd40000, 16'hFFFE, 8'h22);
        send_update(16'd40000, 16'hFFFE, 8'h23);
        send_update(16'd65535, 16'hFFFE, 8'h24);
        send_update(16'd0,     16'hFFFF, 8'h25);
        send_update(16'd65535, 16'hFFFF, 8'h26);
        wait_until_idle();
        apply_settings(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0);
        for (int n = 0; n < 14; n++)
            send_update(16'($urandom_range(0, 2)), 16'($urandom), 8'($urandom));
        wait_until_idle();
    endtask

    // Several random settings, each with a run of random click and hold traffic.
    task automatic test_random_phases();
        for (int p = 0; p < 4; p++) begin
            apply_random_settings();
            run_random_updates(50);
            wait_until_idle();
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_final_no_idle();
        idle_en = 1'b0;
        apply_random_settings();
        run_random_updates(40);
        wait_until_idle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        reset_shadow();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_click_all_buttons();
        test_hold_and_silent_release();
        test_config_extremes();
        test_random_phases();
        test_final_no_idle();

        if (pending_events.size() != 0)
            report_mismatch("events never received", pending_events.size(), 0);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
